// File: design/positional_array_list_top_defines.svh
// Assertion macros of the positional list design, used by its top level.
`ifndef POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`ifndef SYNTH
// Checked on every rising edge of clk, switched off while rst_n is low.
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define PAL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAL_ASSERT(lbl, prop, msg)
`define PAL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/pal_pkg.sv
// Package with the field widths, operation and status codes and shared types of the list.
package pal_pkg;

  // Field widths of the beats and of the register port.
  localparam int MODE_W     = 3;
  localparam int POS_W      = 9;
  localparam int WORD_W     = 32;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 9;
  localparam int CAP_W      = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Fan-in of one node of the removed-word collection tree.
  localparam int RADIX_LOG = 4;
  localparam int RADIX     = 1 << RADIX_LOG;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_START = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_POS   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM_START = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM_END   = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

  // Register index, taken from paddr bit 2.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic accept;
    logic insert;
    logic remove;
  } pal_cmd_t;

endpackage

// File: design/pal_if.sv
// Handshake interfaces of the request and result channels.
interface pal_in_if;
  import pal_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   entry_in;

  modport source (output valid, output mode, output position, output entry_in, input ready);
  modport sink (input valid, input mode, input position, input entry_in, output ready);
endinterface

interface pal_out_if;
  import pal_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [WORD_W-1:0]   removed_entry;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output removed_entry, output entry_count,
                  input ready);
  modport sink (input valid, input status, input removed_entry, input entry_count,
                output ready);
endinterface

// File: design/pal_cell.sv
// One list cell: holds one entry and shifts towards its neighbours on insert and remove.
module pal_cell #(
  parameter int IDX_W       = 8,
  parameter int INDEX       = 0,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                   clk,
  input  pal_pkg::pal_cmd_t      cmd_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [ENTRY_WIDTH-1:0] word_i,
  input  logic [ENTRY_WIDTH-1:0] left_i,
  input  logic [ENTRY_WIDTH-1:0] right_i,
  output logic [ENTRY_WIDTH-1:0] value_o,
  output logic [ENTRY_WIDTH-1:0] pick_o
);
  import pal_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [ENTRY_WIDTH-1:0] value_r, value_nxt;
  logic [ENTRY_WIDTH-1:0] pick_r, pick_nxt;
  logic                   at_idx, above_idx;

  assign at_idx    = (idx_i == MyIdx);
  assign above_idx = (MyIdx > idx_i);

  // Insert: cells above the slot take the left neighbour, the slot takes the new word.
  // Remove: the slot and all cells above it take the right neighbour.
  always_comb begin
    value_nxt = value_r;
    if (cmd_i.insert) begin
      if (at_idx) begin
        value_nxt = word_i;
      end else if (above_idx) begin
        value_nxt = left_i;
      end
    end else if (cmd_i.remove) begin
      if (at_idx || above_idx) begin
        value_nxt = right_i;
      end
    end
  end

  // The cell being removed offers its old word to the collection tree; all others offer zero.
  always_comb begin
    pick_nxt = pick_r;
    if (cmd_i.accept) begin
      pick_nxt = (cmd_i.remove && at_idx) ? value_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pick_r  <= pick_nxt;
  end

  assign value_o = value_r;
  assign pick_o  = pick_r;

endmodule

// File: design/pal_or_tree.sv
// Registered OR tree that gathers the single non-zero picked word from the row of cells.
module pal_or_tree #(
  parameter int N = 256,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);
  import pal_pkg::*;

  // Number of nodes on level l; level 0 is the leaves.
  function automatic int lvl_cnt(input int l);
    int c;
    c = N;
    for (int k = 0; k < l; k++) begin
      c = (c + RADIX - 1) >> RADIX_LOG;
    end
    return c;
  endfunction

  // Offset of level l (from 1) in the flat node store.
  function automatic int lvl_off(input int l);
    int o;
    o = 0;
    for (int k = 1; k < l; k++) begin
      o = o + lvl_cnt(k);
    end
    return o;
  endfunction

  localparam int LEVELS = ($clog2(N) + RADIX_LOG - 1) / RADIX_LOG;
  localparam int TOTAL  = lvl_off(LEVELS + 1);

  logic [W-1:0] node_r   [TOTAL];
  logic [W-1:0] node_nxt [TOTAL];

  // Each node ORs up to RADIX children of the level below.
  for (genvar gl = 1; gl <= LEVELS; gl++) begin : g_lvl
    localparam int NPrev   = lvl_cnt(gl - 1);
    localparam int NCur    = lvl_cnt(gl);
    localparam int OffCur  = lvl_off(gl);
    localparam int OffPrev = lvl_off(gl - 1);
    for (genvar gn = 0; gn < NCur; gn++) begin : g_node
      localparam int NLeft = NPrev - gn * RADIX;
      localparam int NCh   = (NLeft > RADIX) ? RADIX : NLeft;
      logic [W-1:0] acc;
      if (gl == 1) begin : g_leaf
        always_comb begin
          acc = '0;
          for (int c = 0; c < NCh; c++) begin
            acc = acc | leaf_i[gn * RADIX + c];
          end
        end
      end else begin : g_inner
        always_comb begin
          acc = '0;
          for (int c = 0; c < NCh; c++) begin
            acc = acc | node_r[OffPrev + gn * RADIX + c];
          end
        end
      end
      assign node_nxt[OffCur + gn] = acc;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  assign root_o = node_r[TOTAL - 1];

endmodule

// File: design/positional_array_list_top.sv
// Top level of the positional list: request decode, cell row, result register and APB port.
//
// Bounded ordered list of entry words held in a row of DEPTH cells, one entry per cell.
// Request channel in_ch carries mode, position and entry_in; each beat gives exactly one
// beat on out_ch with status, removed_entry and entry_count after the operation.
// Inserts and removes update every cell at the clock edge that accepts the request beat:
// cells above the slot shift one place, so the whole list is updated at that edge.
// The removed word is collected from the cells by a registered OR tree of radix 16.
// One request is in flight at a time: the next request beat is not accepted until the
// result of the last one has been loaded into the output register.
// A finished result sits in the output register; the next request is accepted while it
// waits, and that request's result is held back until the receiver takes the first one.
// APB register 0 (capacity_limit, byte address 0) caps the entry count; it resets to 256.
// Reset empties the list at once (count cleared, no clearing pass) and drops any result
// still waiting.
`include "positional_array_list_top_defines.svh"

module positional_array_list_top #(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pal_in_if.sink                             in_ch,
  pal_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pal_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pal_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pal_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import pal_pkg::*;

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMP_W  = (CW > POS_W) ? CW : POS_W;
  localparam int EXT_W  = (ENTRY_WIDTH > WORD_W) ? ENTRY_WIDTH : WORD_W;
  localparam int LEVELS = ($clog2(DEPTH) + RADIX_LOG - 1) / RADIX_LOG;
  localparam int WT_W   = $clog2(LEVELS + 1);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WT_W-1:0]        wait_r, wait_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic [STAT_W-1:0]      stat_pend_r, stat_pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [WORD_W-1:0]      out_removed_r, out_removed_nxt;
  logic [CNT_W-1:0]       out_count_r, out_count_nxt;

  logic                   in_ready, in_acc, slot_free, cfg_wr;
  logic                   is_ins, is_rem, full, empty, badpos, ins_ok, rem_ok;
  logic [CMP_W-1:0]       pos_cmp, cnt_cmp, cap_cmp, depth_cmp;
  logic [CW-1:0]          cnt_dec;
  logic [IDX_W-1:0]       idx;
  logic [STAT_W-1:0]      status_dec;
  logic [EXT_W-1:0]       word_ext, rem_ext;
  pal_cmd_t               cmd;

  logic [ENTRY_WIDTH-1:0] cell_val  [DEPTH];
  logic [ENTRY_WIDTH-1:0] cell_pick [DEPTH];
  logic [ENTRY_WIDTH-1:0] tree_out;

  // Handshakes.
  assign in_ready     = (state_r == S_IDLE);
  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign slot_free    = !out_valid_r || out_ch.ready;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

  // Operand alignment for the compares.
  assign pos_cmp   = CMP_W'(in_ch.position);
  assign cnt_cmp   = CMP_W'(count_r);
  assign cap_cmp   = CMP_W'(cap_r);
  assign depth_cmp = CMP_W'(DEPTH);
  assign cnt_dec   = count_r - CW'(1);
  assign full      = (cnt_cmp >= cap_cmp) || (cnt_cmp >= depth_cmp);
  assign empty     = (count_r == '0);
  assign word_ext  = EXT_W'(in_ch.entry_in);

  // Request decode: kind of operation, target slot and bad position.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    badpos = 1'b0;
    idx    = '0;
    case (in_ch.mode)
      MODE_INS_POS: begin
        is_ins = 1'b1;
        if (in_ch.position == '0) begin
          idx = '0;
        end else if (pos_cmp >= cnt_cmp) begin
          idx = count_r[IDX_W-1:0];
        end else begin
          idx = pos_cmp[IDX_W-1:0];
        end
      end
      MODE_INS_START: begin
        is_ins = 1'b1;
      end
      MODE_INS_END: begin
        is_ins = 1'b1;
        idx    = count_r[IDX_W-1:0];
      end
      MODE_REM_POS: begin
        is_rem = 1'b1;
        badpos = (pos_cmp >= cnt_cmp);
        idx    = pos_cmp[IDX_W-1:0];
      end
      MODE_REM_START: begin
        is_rem = 1'b1;
      end
      MODE_REM_END: begin
        is_rem = 1'b1;
        idx    = cnt_dec[IDX_W-1:0];
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  // Status of the operation; a failed one leaves the list untouched.
  always_comb begin
    ins_ok     = is_ins && !full;
    rem_ok     = is_rem && !empty && !badpos;
    status_dec = STAT_OK;
    if (is_ins && full) begin
      status_dec = STAT_FULL;
    end else if (is_rem && empty) begin
      status_dec = STAT_EMPTY;
    end else if (is_rem && badpos) begin
      status_dec = STAT_BADPOS;
    end
  end

  // Command broadcast to the cell row.
  always_comb begin
    cmd.accept = in_acc;
    cmd.insert = in_acc && ins_ok;
    cmd.remove = in_acc && rem_ok;
  end

  // Row of cells, each wired to its two neighbours; the top cell refills from itself.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    localparam int LeftI  = (gi == 0) ? 0 : gi - 1;
    localparam int RightI = (gi == DEPTH - 1) ? gi : gi + 1;
    pal_cell #(
      .IDX_W       (IDX_W),
      .INDEX       (gi),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .idx_i   (idx),
      .word_i  (word_ext[ENTRY_WIDTH-1:0]),
      .left_i  (cell_val[LeftI]),
      .right_i (cell_val[RightI]),
      .value_o (cell_val[gi]),
      .pick_o  (cell_pick[gi])
    );
  end

  // Collection of the removed word.
  pal_or_tree #(
    .N (DEPTH),
    .W (ENTRY_WIDTH)
  ) u_tree (
    .clk    (clk),
    .leaf_i (cell_pick),
    .root_o (tree_out)
  );

  assign rem_ext = EXT_W'(tree_out);

  // Sequencer: count, pending status, wait for the tree and load the result register.
  always_comb begin
    state_nxt       = state_r;
    wait_nxt        = wait_r;
    count_nxt       = count_r;
    stat_pend_nxt   = stat_pend_r;
    cap_nxt         = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt     = S_WAIT;
          wait_nxt      = WT_W'(LEVELS);
          stat_pend_nxt = status_dec;
          if (ins_ok) begin
            count_nxt = count_r + CW'(1);
          end else if (rem_ok) begin
            count_nxt = cnt_dec;
          end
        end
      end
      S_WAIT: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - WT_W'(1);
        end else if (slot_free) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = stat_pend_r;
          out_removed_nxt = rem_ext[WORD_W-1:0];
          out_count_nxt   = CNT_W'(count_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    stat_pend_r   <= stat_pend_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

  // Result beat.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_entry = out_removed_r;
  assign out_ch.entry_count   = out_count_r;

  // Checks on the list control.
  `PAL_ASSERT_RST(a_reset_empties, !rst_n |=> count_r == '0, "count not cleared by reset")
  `PAL_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `PAL_ASSERT(a_one_in_flight, in_acc |=> !in_ready, "request taken while one in flight")
  `PAL_ASSERT(a_insert_counts, in_acc && ins_ok |=> count_r == $past(count_r) + CW'(1), "count stuck")
  `PAL_ASSERT(a_fail_no_word, out_valid_r && out_status_r != STAT_OK |-> out_removed_r == '0, "stray word")

endmodule

// File: tb/tb_positional_array_list_top.sv
// Self-checking testbench of the positional list: directed and random requests, APB capacity writes.
`timescale 1ns / 100ps

module tb_positional_array_list_top;
  import pal_pkg::*;

  localparam int DEPTH       = 256;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 9;
  localparam int REPORT_MAX  = 10;

  // Mode codes that the block leaves unused.
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] entry;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] removed;
    logic [CNT_W-1:0]  count;
  } list_resp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pal_in_if  in_bus ();
  pal_out_if out_bus ();

  positional_array_list_top #(
    .DEPTH      (DEPTH),
    .ENTRY_WIDTH(WORD_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted list contents and capacity register.
  logic [WORD_W-1:0] list_words[$];
  logic [CAP_W-1:0]  capacity_reg;

  list_req_t  req_pending[$];
  list_resp_t expected_results[$];
  list_req_t  driven_req;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int requests_accepted;
  int results_checked;
  int full_seen;
  int empty_seen;
  int badpos_seen;
  int peak_count;
  int settings_used;
  int cycle_count;

  logic [MODE_W-1:0] insert_modes[3] = '{MODE_INS_POS, MODE_INS_START, MODE_INS_END};
  logic [MODE_W-1:0] remove_modes[3] = '{MODE_REM_POS, MODE_REM_START, MODE_REM_END};

  // Random phases: capacity, number of requests and share of inserts in percent.
  int phase_cap[N_PHASES]   = '{256, 100, 0, 511, 1, 12, 300, 2, 37};
  int phase_items[N_PHASES] = '{400, 100, 60, 150, 80, 150, 100, 80, 80};
  int phase_ins[N_PHASES]   = '{90, 40, 60, 50, 50, 55, 30, 50, 60};

  // Clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int effective_limit();
    return (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
  endfunction

  // Applies one request to the predicted list and returns the result it should give.
  function automatic list_resp_t apply_list_op(list_req_t r);
    list_resp_t res;
    int         cnt;
    res        = '0;
    res.status = STAT_OK;
    cnt        = list_words.size();
    case (r.mode)
      MODE_INS_POS, MODE_INS_START, MODE_INS_END: begin
        if (cnt >= effective_limit()) begin
          res.status = STAT_FULL;
        end else if (r.mode == MODE_INS_START || (r.mode == MODE_INS_POS && r.position == 0)) begin
          list_words.push_front(r.entry);
        end else if (r.mode == MODE_INS_END || r.position >= cnt) begin
          list_words.push_back(r.entry);
        end else begin
          list_words.insert(r.position, r.entry);
        end
      end
      MODE_REM_POS, MODE_REM_START, MODE_REM_END: begin
        if (cnt == 0) begin
          res.status = STAT_EMPTY;
        end else if (r.mode == MODE_REM_START) begin
          res.removed = list_words.pop_front();
        end else if (r.mode == MODE_REM_END) begin
          res.removed = list_words.pop_back();
        end else if (r.position >= cnt) begin
          res.status = STAT_BADPOS;
        end else begin
          res.removed = list_words[r.position];
          list_words.delete(r.position);
        end
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(list_words.size());
    return res;
  endfunction

  function automatic list_req_t make_req(logic [MODE_W-1:0] mode, int position,
                                         logic [WORD_W-1:0] entry);
    list_req_t r;
    r.mode     = mode;
    r.position = POS_W'(position);
    r.entry    = entry;
    return r;
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Queues random requests; most keep positions in range for the count they will meet.
  task automatic queue_random(int n, int ins_pct);
    list_req_t r;
    int        c;
    int        pick;
    logic      is_insert;
    logic      is_remove;
    c = list_words.size();
    repeat (n) begin
      r.entry   = $urandom();
      pick      = $urandom_range(0, 99);
      is_insert = 1'b0;
      is_remove = 1'b0;
      if (pick < 3) begin
        r.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      end else if (pick < 3 + (ins_pct * 97) / 100) begin
        r.mode    = insert_modes[$urandom_range(0, 2)];
        is_insert = 1'b1;
      end else begin
        r.mode    = remove_modes[$urandom_range(0, 2)];
        is_remove = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      end else if (is_insert || c == 0) begin
        r.position = POS_W'($urandom_range(0, c));
      end else begin
        r.position = POS_W'($urandom_range(0, c - 1));
      end
      // Track the count so that later positions stay relevant.
      if (is_insert && c < effective_limit()) begin
        c++;
      end else if (is_remove && c > 0 && (r.mode != MODE_REM_POS || r.position < c)) begin
        c--;
      end
      req_pending.push_back(r);
    end
  endtask

  // Waits until every request has been sent and answered, then lets the pipeline drain.
  // The check is made at the falling edge, once the driver and monitor have settled.
  task automatic wait_quiet();
    do begin
      @(negedge clk);
    end while (req_pending.size() != 0 || in_bus.valid || expected_results.size() != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // APB write of the capacity register followed by a read back.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    capacity_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (prdata !== CFG_DATA_W'(value)) begin
      note_mismatch($sformatf("capacity read back: expected %0d, got %0d", value, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Request driver: predicts each accepted beat and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(apply_list_op(driven_req));
        requests_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (req_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_req = req_pending.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.mode     <= driven_req.mode;
          in_bus.position <= driven_req.position;
          in_bus.entry_in <= driven_req.entry;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    list_resp_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("result with none expected: status %0d removed %h count %0d",
                                  out_bus.status, out_bus.removed_entry, out_bus.entry_count));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_bus.status !== want.status || out_bus.removed_entry !== want.removed ||
              out_bus.entry_count !== want.count) begin
            note_mismatch($sformatf(
              "expected status %0d removed %h count %0d, got status %0d removed %h count %0d",
              want.status, want.removed, want.count,
              out_bus.status, out_bus.removed_entry, out_bus.entry_count));
          end
          case (want.status)
            STAT_FULL:   full_seen++;
            STAT_EMPTY:  empty_seen++;
            STAT_BADPOS: badpos_seen++;
            default: begin
            end
          endcase
          if (want.count > peak_count) peak_count = want.count;
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("FAIL positional_array_list_top");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_bus.valid    = 1'b0;
    in_bus.mode     = '0;
    in_bus.position = '0;
    in_bus.entry_in = '0;
    out_bus.ready   = 1'b0;
    capacity_reg    = CAP_RESET;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty list, every insert form, full list, bad positions, spare modes.
    write_capacity(CAP_W'(5));
    req_pending.push_back(make_req(MODE_REM_END, 0, 32'h0));
    req_pending.push_back(make_req(MODE_REM_START, 0, 32'h0));
    req_pending.push_back(make_req(MODE_REM_POS, 0, 32'h0));
    req_pending.push_back(make_req(MODE_INS_POS, 0, 32'hFFFF_FFFF));
    req_pending.push_back(make_req(MODE_INS_START, 0, 32'h0000_0000));
    req_pending.push_back(make_req(MODE_INS_END, 0, 32'h1234_5678));
    req_pending.push_back(make_req(MODE_INS_POS, 1, 32'h5A5A_5A5A));
    req_pending.push_back(make_req(MODE_INS_POS, 256, 32'hA5A5_A5A5));
    req_pending.push_back(make_req(MODE_INS_START, 0, 32'hDEAD_BEEF));
    req_pending.push_back(make_req(MODE_INS_END, 0, 32'hCAFE_F00D));
    req_pending.push_back(make_req(MODE_INS_POS, 2, 32'h8000_0001));
    req_pending.push_back(make_req(MODE_REM_POS, 5, 32'h0));
    req_pending.push_back(make_req(MODE_REM_POS, 511, 32'hFFFF_FFFF));
    req_pending.push_back(make_req(MODE_REM_POS, 2, 32'h0));
    req_pending.push_back(make_req(MODE_REM_START, 0, 32'h0));
    req_pending.push_back(make_req(MODE_REM_END, 0, 32'h0));
    req_pending.push_back(make_req(MODE_SPARE_6, 3, 32'h1111_1111));
    req_pending.push_back(make_req(MODE_SPARE_7, 511, 32'hFFFF_FFFF));
    req_pending.push_back(make_req(MODE_REM_POS, 1, 32'h0));
    req_pending.push_back(make_req(MODE_REM_POS, 0, 32'h0));
    req_pending.push_back(make_req(MODE_REM_POS, 0, 32'h0));
    wait_quiet();

    // Random phases under changing capacity and handshake pressure.
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      queue_random(phase_items[p], phase_ins[p]);
      wait_quiet();
    end

    repeat (LATENCY + 2) @(posedge clk);
    $display("Checked %0d results from %0d requests under %0d capacity settings.",
             results_checked, requests_accepted, settings_used);
    $display("Full answers %0d, empty answers %0d, bad positions %0d, peak count %0d.",
             full_seen, empty_seen, badpos_seen, peak_count);
    if (mismatch_count == 0) begin
      $display("PASS positional_array_list_top");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("FAIL positional_array_list_top");
    end
    $finish;
  end

endmodule

// File: positional_array_list_top.f
+incdir+design
design/pal_pkg.sv
design/pal_if.sv
design/pal_cell.sv
design/pal_or_tree.sv
design/positional_array_list_top.sv
tb/tb_positional_array_list_top.sv
